FILE: design/ctb_pkg.sv
package ctb_pkg;

  localparam int MAX_NODES = 1024;
  localparam int ADDR_W    = $clog2(MAX_NODES);
  localparam int CNT_W     = ADDR_W + 1;
  localparam int KEY_W     = 32;
  localparam int IDX_W     = 10;
  localparam int OUT_W     = 48;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_LOAD
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic pop;
    logic load;
    logic finish;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic do_pop;
    logic out_free;
  } status_t;

endpackage

FILE: design/ctb_ctrl.sv
module ctb_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  ctb_pkg::status_t status,
  output ctb_pkg::cmd_t    cmd
);
  import ctb_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EVAL;
      end
      S_EVAL: begin
        if (status.do_pop) state_next = S_LOAD;
        else if (status.out_free) state_next = S_IDLE;
      end
      S_LOAD: begin
        state_next = S_EVAL;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.pop     = 1'b0;
    cmd.load    = 1'b0;
    cmd.finish  = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      S_EVAL: begin
        cmd.pop    = status.do_pop;
        cmd.finish = !status.do_pop && status.out_free;
      end
      S_LOAD: begin
        cmd.load = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // a pop or a finish only happens while an item is being evaluated
  assert property (@(posedge clk) disable iff (rst)
    (cmd.pop || cmd.finish) |-> state == S_EVAL)
    else $error("evaluation step without a captured item");

  // a load always follows the pop that fetched the new top
  assert property (@(posedge clk) disable iff (rst)
    cmd.pop |=> cmd.load)
    else $error("pop not followed by a top load");

  assert property (@(posedge clk) disable iff (rst)
    !(cmd.pop && cmd.finish))
    else $error("pop and finish in the same cycle");

endmodule

FILE: design/ctb_datapath.sv
module ctb_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  logic signed [ctb_pkg::KEY_W-1:0] in_key,
  input  logic                          in_last,
  input  ctb_pkg::cmd_t                 cmd,
  output ctb_pkg::status_t              status,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ctb_pkg::OUT_W-1:0]     out_data,
  output logic                          out_overflow
);
  import ctb_pkg::*;

  // stack storage, top entry mirrored in registers
  logic signed [KEY_W-1:0]  key_mem [MAX_NODES];
  logic        [ADDR_W-1:0] idx_mem [MAX_NODES];
  logic signed [KEY_W-1:0]  rd_key;
  logic        [ADDR_W-1:0] rd_idx;

  logic signed [KEY_W-1:0]  key;
  logic                     last;
  logic signed [KEY_W-1:0]  top_key;
  logic        [ADDR_W-1:0] top_idx;
  logic        [ADDR_W-1:0] bottom_idx;
  logic        [CNT_W-1:0]  depth;
  logic        [CNT_W-1:0]  next_index;
  logic                     acc_has_left;
  logic        [ADDR_W-1:0] acc_left;

  logic                     full;
  logic                     stack_empty;
  logic        [ADDR_W-1:0] new_idx;
  logic        [ADDR_W-1:0] rd_addr;
  logic                     r_has_parent;
  logic                     r_root_valid;
  logic        [ADDR_W-1:0] r_root;

  assign full        = (next_index == CNT_W'(MAX_NODES));
  assign stack_empty = (depth == '0);
  assign new_idx     = next_index[ADDR_W-1:0];
  assign rd_addr     = depth[ADDR_W-1:0] - ADDR_W'(2);

  assign status.do_pop   = !full && !stack_empty && (top_key < key);
  assign status.out_free = !out_valid || out_ready;

  assign r_has_parent = !full && !stack_empty;
  assign r_root_valid = last && (!full || !stack_empty);
  assign r_root       = (!full && stack_empty) ? new_idx : bottom_idx;

  always_ff @(posedge clk) begin
    if (cmd.finish && !full) begin
      key_mem[depth[ADDR_W-1:0]] <= key;
      idx_mem[depth[ADDR_W-1:0]] <= new_idx;
    end
    if (cmd.pop) begin
      rd_key <= key_mem[rd_addr];
      rd_idx <= idx_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      key <= in_key;
      last <= in_last;
    end
    if (cmd.load) begin
      top_key <= rd_key;
      top_idx <= rd_idx;
    end else if (cmd.finish && !full) begin
      top_key <= key;
      top_idx <= new_idx;
    end
    if (cmd.finish && !full && stack_empty) begin
      bottom_idx <= new_idx;
    end
    if (cmd.pop) begin
      acc_left <= top_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depth        <= '0;
      next_index   <= '0;
      acc_has_left <= 1'b0;
    end else begin
      if (cmd.capture) begin
        acc_has_left <= 1'b0;
      end else if (cmd.pop) begin
        acc_has_left <= 1'b1;
      end
      if (cmd.pop) begin
        depth <= depth - CNT_W'(1);
      end else if (cmd.finish) begin
        if (last) begin
          depth      <= '0;
          next_index <= '0;
        end else if (!full) begin
          depth      <= depth + CNT_W'(1);
          next_index <= next_index + CNT_W'(1);
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_data[9:0]   <= full ? '0 : IDX_W'(new_idx);
      out_data[10]    <= acc_has_left && !full;
      out_data[20:11] <= (acc_has_left && !full) ? IDX_W'(acc_left) : '0;
      out_data[21]    <= r_has_parent;
      out_data[31:22] <= r_has_parent ? IDX_W'(top_idx) : '0;
      out_data[32]    <= r_root_valid;
      out_data[42:33] <= r_root_valid ? IDX_W'(r_root) : '0;
      out_data[47:43] <= '0;
      out_overflow    <= full;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    depth <= next_index)
    else $error("stack deeper than nodes inserted");

  assert property (@(posedge clk) disable iff (rst)
    next_index <= CNT_W'(MAX_NODES))
    else $error("node counter past capacity");

  assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> !stack_empty)
    else $error("pop from an empty stack");

  assert property (@(posedge clk) disable iff (rst)
    cmd.finish && last |=> depth == '0 && next_index == '0)
    else $error("sequence end did not restart the stack");

endmodule

FILE: design/cartesian_tree_builder.sv
// channel | dir | handshake          | payload
// s_      | in  | s_tvalid/s_tready  | s_tdata value, s_tlast is_last
// m_      | out | m_tvalid/m_tready  | m_tdata tree update record, m_tuser overflow
//
// for every stack entry an item pops, the next entry is read from the stack memory and then
// loaded as top, after which the item is evaluated again;
// each node is popped at most once, so a sequence pops no more entries than it has items
// the result register lets the next item enter while the last result waits
// rst is synchronous; the stack memory needs no clearing, only the depth and node counters reset
// a stalled m_ side holds the finished item in evaluation until the register frees
module cartesian_tree_builder (
  input  logic        clk,
  input  logic        rst,
  // value
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,    // [31:0] value (signed)
  input  logic        s_tlast,    // is_last
  // update record
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,    // [9:0] node_index, [10] has_left, [20:11] left_child,
                                  // [21] has_parent, [31:22] parent_node,
                                  // [32] root_valid, [42:33] root_node, [47:43] zero
  output logic        m_tuser     // overflow
);
  import ctb_pkg::*;

  cmd_t    cmd;
  status_t status;

  // sequencer: capture, pop loop, push and result
  ctb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // stack memory, cached top, counters and result register
  ctb_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .in_key       (s_tdata),
    .in_last      (s_tlast),
    .cmd          (cmd),
    .status       (status),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_data     (m_tdata),
    .out_overflow (m_tuser)
  );

endmodule
